FILE: rtl/core/gea_pkg.sv
// Package for the greedy transport cost block: sizes, operation codes and
// controller states. It depends on nothing else.
package gea_pkg;
    localparam int MAX_POINTS   = 64;
    localparam int MAX_MEANS    = 64;
    localparam int NUM_CLUSTERS = 512;
    localparam int PW = $clog2(MAX_POINTS);
    localparam int MW = $clog2(MAX_MEANS);
    localparam int CW = $clog2(NUM_CLUSTERS);
    localparam int TW = CW + MW;
    localparam int TDEPTH = NUM_CLUSTERS * MAX_MEANS;
    localparam logic [39:0] COST_MAX = 40'hFF_FFFF_FFFF;

    typedef enum logic [1:0] {
        OP_POINT = 2'd0,
        OP_MEAN  = 2'd1,
        OP_TABLE = 2'd2,
        OP_COMP  = 2'd3
    } op_t;

    typedef enum logic [2:0] {
        ST_IDLE, ST_INIT, ST_READ, ST_WAIT, ST_FETCH, ST_EVAL, ST_ADD, ST_OUT
    } state_t;

    typedef struct packed {
        logic load;
        logic init;
        logic init_step;
        logic eval;
        logic add;
        logic advance;
    } cmd_t;

    typedef struct packed {
        logic init_done;
        logic walk_done;
    } sts_t;
endpackage

FILE: rtl/core/greedy_emd_approximation.sv
// Greedy transport cost block, one request at a time: a load request is taken in the idle
// state and loads may follow back to back. A compute request copies the masses, then
// steps each rank and point cell through ST_READ, ST_WAIT, ST_FETCH, ST_EVAL and ST_ADD
// for R means and P points after clamping, and then presents its result; the next
// request waits until the result leaves. Reset (synchronous, active low) clears the
// controller, the finished flags and the cost accumulator; the stores start undefined.
module greedy_emd_approximation import gea_pkg::*; (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_valid,
    output logic        s_ready,
    input  logic [1:0]  s_operation,
    input  logic [5:0]  s_slot,
    input  logic [8:0]  s_cluster,
    input  logic [16:0] s_weight,
    input  logic [19:0] s_distance,
    input  logic [5:0]  s_target_mean,
    input  logic [6:0]  s_point_count,
    input  logic [6:0]  s_mean_count,
    output logic        m_valid,
    input  logic        m_ready,
    output logic [39:0] m_total_cost,
    output logic        m_saturated
);
    cmd_t cmd;
    sts_t sts;

    gea_ctrl u_ctrl (
        .aclk(aclk), .aresetn(aresetn), .s_valid(s_valid), .s_ready(s_ready),
        .s_operation(s_operation), .m_valid(m_valid), .m_ready(m_ready),
        .sts(sts), .cmd(cmd)
    );

    gea_dp u_dp (
        .aclk(aclk), .aresetn(aresetn), .cmd(cmd), .sts(sts),
        .s_operation(s_operation), .s_slot(s_slot), .s_cluster(s_cluster),
        .s_weight(s_weight), .s_distance(s_distance),
        .s_target_mean(s_target_mean), .s_point_count(s_point_count),
        .s_mean_count(s_mean_count), .m_total_cost(m_total_cost),
        .m_saturated(m_saturated)
    );

    a_sat_max: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_saturated |-> m_total_cost == COST_MAX)
        else $error("saturated result without maximum cost");
    a_no_accept_busy: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> !s_ready)
        else $error("input taken while a result is pending");
    a_one_phase: assert property (@(posedge aclk) disable iff (!aresetn)
        !(cmd.eval && cmd.add))
        else $error("evaluate and accumulate overlap");
endmodule

FILE: rtl/core/gea_ram.sv
// Generic single-port-write RAM with one registered read port.
// No dependencies.
module gea_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);
    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end
endmodule

FILE: rtl/core/gea_ctrl.sv
// Controller state machine for the transport cost block.
// Depends on gea_pkg.
module gea_ctrl import gea_pkg::*; (
    input  logic aclk,
    input  logic aresetn,
    input  logic s_valid,
    output logic s_ready,
    input  logic [1:0] s_operation,
    output logic m_valid,
    input  logic m_ready,
    input  sts_t sts,
    output cmd_t cmd
);
    state_t state_reg, state_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    always_comb begin
        state_next = state_reg;
        cmd = '0;
        s_ready = 1'b0;
        m_valid = 1'b0;
        unique case (state_reg)
            ST_IDLE: begin
                s_ready = 1'b1;
                if (s_valid) begin
                    if (op_t'(s_operation) == OP_COMP) begin
                        cmd.init = 1'b1;
                        state_next = ST_INIT;
                    end else begin
                        cmd.load = 1'b1;
                    end
                end
            end
            ST_INIT: begin
                cmd.init_step = 1'b1;
                if (sts.init_done) state_next = ST_READ;
            end
            ST_READ: begin
                if (sts.walk_done) begin
                    state_next = ST_OUT;
                end else begin
                    state_next = ST_WAIT;
                end
            end
            ST_WAIT: state_next = ST_FETCH;
            ST_FETCH: state_next = ST_EVAL;
            ST_EVAL: begin
                cmd.eval = 1'b1;
                state_next = ST_ADD;
            end
            ST_ADD: begin
                cmd.add = 1'b1;
                cmd.advance = 1'b1;
                state_next = ST_READ;
            end
            ST_OUT: begin
                m_valid = 1'b1;
                if (m_ready) state_next = ST_IDLE;
            end
            default: state_next = ST_IDLE;
        endcase
    end
endmodule

FILE: rtl/core/gea_dp.sv
// Datapath: point and mean stores, distance table RAMs, mass bookkeeping
// and the saturating cost accumulator. Depends on gea_pkg and gea_ram.
module gea_dp import gea_pkg::*; (
    input  logic        aclk,
    input  logic        aresetn,
    input  cmd_t        cmd,
    output sts_t        sts,
    input  logic [1:0]  s_operation,
    input  logic [5:0]  s_slot,
    input  logic [8:0]  s_cluster,
    input  logic [16:0] s_weight,
    input  logic [19:0] s_distance,
    input  logic [5:0]  s_target_mean,
    input  logic [6:0]  s_point_count,
    input  logic [6:0]  s_mean_count,
    output logic [39:0] m_total_cost,
    output logic        m_saturated
);
    logic [MAX_POINTS-1:0] pfin_reg;

    logic [PW:0] npts_reg;
    logic [MW:0] nmeans_reg;
    logic [MW:0] init_reg;
    logic [PW:0] p_reg;
    logic [MW:0] r_reg;
    logic [39:0] cost_reg;
    logic        sat_reg;
    logic [36:0] prod_reg;
    logic        skip_reg;

    logic [19:0] tdist;
    logic [5:0]  tmean;
    logic        twe;
    logic [TW-1:0] twaddr, traddr;
    logic [PW-1:0] pidx;
    logic [CW-1:0] prow;
    logic          pwe, mwe;
    logic          init_wr_en;
    logic [MW:0]   init_wr;
    logic [16:0]   pw_rd, mw_rd;
    logic          pl_we, ml_we;
    logic [PW-1:0] pl_waddr;
    logic [MW-1:0] ml_waddr;
    logic [16:0]   pl_wdata, ml_wdata;
    logic [16:0]   avail, need, mass;
    logic [MW-1:0] midx;
    logic          m_ok, move;

    assign pidx = p_reg[PW-1:0];
    assign twe = cmd.load && op_t'(s_operation) == OP_TABLE
                 && ({1'b0, s_slot} < 7'(MAX_MEANS))
                 && ({1'b0, s_cluster} < 10'(NUM_CLUSTERS));
    assign twaddr = {s_cluster[CW-1:0], s_slot[MW-1:0]};
    assign traddr = {prow, r_reg[MW-1:0]};
    assign pwe = cmd.load && op_t'(s_operation) == OP_POINT
                 && ({1'b0, s_slot} < 7'(MAX_POINTS));
    assign mwe = cmd.load && op_t'(s_operation) == OP_MEAN
                 && ({1'b0, s_slot} < 7'(MAX_MEANS));
    assign init_wr_en = cmd.init_step && init_reg != '0;
    assign init_wr = init_reg - 1'b1;

    gea_ram #(.WIDTH(20), .DEPTH(TDEPTH)) u_tdist (
        .aclk(aclk), .we(twe), .waddr(twaddr), .wdata(s_distance),
        .raddr(traddr), .rdata(tdist)
    );
    gea_ram #(.WIDTH(6), .DEPTH(TDEPTH)) u_tmean (
        .aclk(aclk), .we(twe), .waddr(twaddr), .wdata(s_target_mean),
        .raddr(traddr), .rdata(tmean)
    );
    gea_ram #(.WIDTH(CW), .DEPTH(MAX_POINTS)) u_pclu (
        .aclk(aclk), .we(pwe), .waddr(s_slot[PW-1:0]), .wdata(s_cluster[CW-1:0]),
        .raddr(pidx), .rdata(prow)
    );
    gea_ram #(.WIDTH(17), .DEPTH(MAX_POINTS)) u_pw (
        .aclk(aclk), .we(pwe), .waddr(s_slot[PW-1:0]), .wdata(s_weight),
        .raddr(init_reg[PW-1:0]), .rdata(pw_rd)
    );
    gea_ram #(.WIDTH(17), .DEPTH(MAX_MEANS)) u_mw (
        .aclk(aclk), .we(mwe), .waddr(s_slot[MW-1:0]), .wdata(s_weight),
        .raddr(init_reg[MW-1:0]), .rdata(mw_rd)
    );
    gea_ram #(.WIDTH(17), .DEPTH(MAX_POINTS)) u_pleft (
        .aclk(aclk), .we(pl_we), .waddr(pl_waddr), .wdata(pl_wdata),
        .raddr(pidx), .rdata(need)
    );
    gea_ram #(.WIDTH(17), .DEPTH(MAX_MEANS)) u_mleft (
        .aclk(aclk), .we(ml_we), .waddr(ml_waddr), .wdata(ml_wdata),
        .raddr(midx), .rdata(avail)
    );

    logic [PW:0] npts_c;
    logic [MW:0] nmeans_c;
    always_comb begin
        npts_c = (s_point_count > 7'(MAX_POINTS)) ? (PW+1)'(MAX_POINTS)
                                                  : (PW+1)'(s_point_count);
        nmeans_c = (s_mean_count > 7'(MAX_MEANS)) ? (MW+1)'(MAX_MEANS)
                                                  : (MW+1)'(s_mean_count);
    end

    always_comb begin
        midx  = tmean[MW-1:0];
        m_ok  = ({2'b0, tmean} < 8'(nmeans_reg));
        move  = !pfin_reg[pidx] && m_ok && avail != '0;
        mass  = (avail < need) ? avail : need;
        pl_we = (init_wr_en && init_wr < (MW+1)'(MAX_POINTS)) || (cmd.eval && move);
        ml_we = (init_wr_en && init_wr < (MW+1)'(MAX_MEANS)) || (cmd.eval && move);
        pl_waddr = cmd.eval ? pidx : init_wr[PW-1:0];
        ml_waddr = cmd.eval ? midx : init_wr[MW-1:0];
        pl_wdata = cmd.eval ? need - mass : pw_rd;
        ml_wdata = cmd.eval ? avail - mass : mw_rd;
    end

    logic [40:0] sum;
    assign sum = {1'b0, cost_reg} + 41'(prod_reg);

    assign sts.init_done = (init_reg >= (MW+1)'(MAX_MEANS))
                           && (init_reg >= (MW+1)'(MAX_POINTS));
    assign sts.walk_done = (r_reg >= nmeans_reg) || (npts_reg == '0);

    always_ff @(posedge aclk) begin
        if (cmd.eval) begin
            skip_reg <= !move;
            prod_reg <= mass * tdist;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pfin_reg <= '0;
            init_reg <= '0;
            p_reg <= '0;
            r_reg <= '0;
            npts_reg <= '0;
            nmeans_reg <= '0;
            cost_reg <= '0;
            sat_reg <= 1'b0;
        end else begin
            if (cmd.init) begin
                npts_reg <= npts_c;
                nmeans_reg <= nmeans_c;
                init_reg <= '0;
                p_reg <= '0;
                r_reg <= '0;
                cost_reg <= '0;
                sat_reg <= 1'b0;
                for (int i = 0; i < MAX_POINTS; i++) begin
                    if (i < int'(npts_c)) pfin_reg[i] <= 1'b0;
                end
            end
            if (cmd.init_step) init_reg <= init_reg + 1'b1;
            if (cmd.eval && move && !(avail < need)) pfin_reg[pidx] <= 1'b1;
            if (cmd.add && !skip_reg) begin
                if (sum > 41'(COST_MAX)) begin
                    cost_reg <= COST_MAX;
                    sat_reg <= 1'b1;
                end else begin
                    cost_reg <= sum[39:0];
                end
            end
            if (cmd.advance) begin
                if (p_reg + 1'b1 >= npts_reg) begin
                    p_reg <= '0;
                    r_reg <= r_reg + 1'b1;
                end else begin
                    p_reg <= p_reg + 1'b1;
                end
            end
        end
    end

    assign m_total_cost = cost_reg;
    assign m_saturated = sat_reg;
endmodule
